// ===== sv/branch_jump_resolve_unit_defines.svh =====
// Assertion macros for the branch and jump resolve unit checker.
// Depends on a clock named i_clk and a synchronous active-low reset named i_rst_n.
`ifndef BRANCH_JUMP_RESOLVE_UNIT_DEFINES_SVH
`define BRANCH_JUMP_RESOLVE_UNIT_DEFINES_SVH

// same-cycle implication, off during reset
`define BRJU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("branch_jump_resolve_unit: check failed");

// next-cycle implication, off during reset
`define BRJU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("branch_jump_resolve_unit: check failed");

// condition that must hold in the cycle after reset is seen
`define BRJU_ASSERT_RESET(lbl, cons) \
    lbl: assert property (@(posedge i_clk) (!i_rst_n) |=> (cons)) \
        else $error("branch_jump_resolve_unit: reset check failed");

`endif

// ===== sv/brju_pkg.sv =====
// Shared types and encodings for the branch and jump resolve unit.
// No dependencies; used by brju_decode and branch_jump_resolve_unit.
package brju_pkg;

    localparam logic [6:0] OP_NOP_ZERO = 7'h00;
    localparam logic [6:0] OP_NOP_HINT = 7'h50;
    localparam logic [6:0] OP_SYSTEM   = 7'h73;
    localparam logic [6:0] OP_IMM      = 7'h13;
    localparam logic [6:0] OP_AUIPC    = 7'h17;
    localparam logic [6:0] OP_BRANCH   = 7'h63;
    localparam logic [6:0] OP_JALR     = 7'h67;
    localparam logic [6:0] OP_JAL      = 7'h6f;

    localparam logic [2:0] F3_ADDI = 3'd0;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_RSV2 = 3'd2;
    localparam logic [2:0] F3_RSV3 = 3'd3;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    typedef enum logic [2:0] {
        K_NOP,
        K_ADDI,
        K_AUIPC,
        K_BRANCH,
        K_JALR,
        K_JAL,
        K_UNSUP
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  f3;
        logic [4:0]  rd;
        logic        use_pc;
        logic [63:0] imm;
    } t_dec;

endpackage

// ===== sv/brju_decode.sv =====
// Instruction decode: classifies the opcode and builds the sign-extended immediate.
// Depends on brju_pkg.
module brju_decode (
    input  logic [31:0]    i_instruction,
    output brju_pkg::t_dec o_dec
);

    logic [6:0]  w_opcode;
    logic [2:0]  w_f3;
    logic [63:0] w_imm_i;
    logic [63:0] w_imm_u;
    logic [63:0] w_imm_b;
    logic [63:0] w_imm_j;

    assign w_opcode = i_instruction[6:0];
    assign w_f3     = i_instruction[14:12];
    assign w_imm_i  = {{52{i_instruction[31]}}, i_instruction[31:20]};
    assign w_imm_u  = {{32{i_instruction[31]}}, i_instruction[31:12], 12'b0};
    assign w_imm_b  = {{51{i_instruction[31]}}, i_instruction[31], i_instruction[7],
                       i_instruction[30:25], i_instruction[11:8], 1'b0};
    assign w_imm_j  = {{43{i_instruction[31]}}, i_instruction[31], i_instruction[19:12],
                       i_instruction[20], i_instruction[30:21], 1'b0};

    always_comb begin
        o_dec.f3     = w_f3;
        o_dec.rd     = i_instruction[11:7];
        o_dec.use_pc = 1'b0;
        o_dec.imm    = w_imm_i;
        o_dec.kind   = brju_pkg::K_UNSUP;
        case (w_opcode)
            brju_pkg::OP_NOP_ZERO, brju_pkg::OP_NOP_HINT, brju_pkg::OP_SYSTEM: begin
                o_dec.kind = brju_pkg::K_NOP;
            end
            brju_pkg::OP_IMM: begin
                if (w_f3 == brju_pkg::F3_ADDI) begin
                    o_dec.kind = brju_pkg::K_ADDI;
                end
            end
            brju_pkg::OP_AUIPC: begin
                o_dec.kind   = brju_pkg::K_AUIPC;
                o_dec.use_pc = 1'b1;
                o_dec.imm    = w_imm_u;
            end
            brju_pkg::OP_BRANCH: begin
                o_dec.use_pc = 1'b1;
                o_dec.imm    = w_imm_b;
                if (!(w_f3 inside {brju_pkg::F3_RSV2, brju_pkg::F3_RSV3})) begin
                    o_dec.kind = brju_pkg::K_BRANCH;
                end
            end
            brju_pkg::OP_JALR: begin
                o_dec.kind = brju_pkg::K_JALR;
            end
            brju_pkg::OP_JAL: begin
                o_dec.kind   = brju_pkg::K_JAL;
                o_dec.use_pc = 1'b1;
                o_dec.imm    = w_imm_j;
            end
            default: begin
                o_dec.kind = brju_pkg::K_UNSUP;
            end
        endcase
    end

endmodule

// ===== sv/branch_jump_resolve_unit.sv =====
// Branch and jump resolve unit: three-stage pipeline for RV64 control flow and simple results.
// Depends on brju_pkg and brju_decode.
//
// Usage:
// - Input channel: i_valid with the instruction, pc, source values and predicted next pc;
//   a transaction completes at a clock edge with i_valid high and o_stall low.
// - Output channel: o_valid with next pc, mispredict, control and write-back fields;
//   a transaction completes at a clock edge with o_valid high and i_stall low.
// - Stage 1 decodes and forms pc+4, stage 2 does the single 64-bit add and the
//   source compares, stage 3 selects the target and compares it with the prediction.
// - An input transaction reaches o_valid through the stage 1, 2 and 3 registers in order.
// - Throughput: one instruction per cycle while the receiver does not stall; every stage holds one instruction.
// - When the receiver stalls, the output stage holds its result and earlier stages
//   keep filling until each holds a valid instruction; then o_stall rises.
// - o_stall depends combinationally on i_stall through the per-stage valid bits.
// - Reset (synchronous, i_rst_n low) empties all stages; payload is not cleared.
module branch_jump_resolve_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [31:0]        i_instruction,
    input  logic [63:0]        i_pc,
    input  logic signed [63:0] i_rs1_value,
    input  logic signed [63:0] i_rs2_value,
    input  logic [63:0]        i_predicted_next_pc,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [63:0]        o_next_pc,
    output logic               o_mispredict,
    output logic               o_is_control,
    output logic               o_branch_taken,
    output logic signed [63:0] o_write_value,
    output logic               o_write_enable,
    output logic [4:0]         o_dest_reg,
    output logic               o_unsupported
);

    brju_pkg::t_dec w_dec;

    logic w_adv1;
    logic w_adv2;
    logic w_adv3;

    logic              r_v1;
    brju_pkg::t_kind   r1_kind;
    logic [2:0]        r1_f3;
    logic [4:0]        r1_rd;
    logic [63:0]       r1_base;
    logic [63:0]       r1_imm;
    logic [63:0]       r1_link;
    logic [63:0]       r1_rs1;
    logic [63:0]       r1_rs2;
    logic [63:0]       r1_pred;

    logic              r_v2;
    brju_pkg::t_kind   r2_kind;
    logic [2:0]        r2_f3;
    logic [4:0]        r2_rd;
    logic [63:0]       r2_sum;
    logic [63:0]       r2_link;
    logic [63:0]       r2_pred;
    logic              r2_eq;
    logic              r2_lts;
    logic              r2_ltu;

    logic              r_v3;
    logic [63:0]       r_next_pc;
    logic              r_mispredict;
    logic              r_is_control;
    logic              r_branch_taken;
    logic [63:0]       r_write_value;
    logic              r_write_enable;
    logic [4:0]        r_dest_reg;
    logic              r_unsupported;

    logic        n_taken;
    logic        n_ctrl;
    logic [63:0] n_next_pc;
    logic [63:0] n_write_value;
    logic        n_write_enable;

    brju_decode u_decode (
        .i_instruction (i_instruction),
        .o_dec         (w_dec)
    );

    assign w_adv3  = !r_v3 || !i_stall;
    assign w_adv2  = !r_v2 || w_adv3;
    assign w_adv1  = !r_v1 || w_adv2;
    assign o_stall = !w_adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= i_valid;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv1) begin
            r1_kind <= w_dec.kind;
            r1_f3   <= w_dec.f3;
            r1_rd   <= w_dec.rd;
            r1_base <= w_dec.use_pc ? i_pc : i_rs1_value;
            r1_imm  <= w_dec.imm;
            r1_link <= i_pc + 64'd4;
            r1_rs1  <= i_rs1_value;
            r1_rs2  <= i_rs2_value;
            r1_pred <= i_predicted_next_pc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r2_kind <= r1_kind;
            r2_f3   <= r1_f3;
            r2_rd   <= r1_rd;
            r2_sum  <= r1_base + r1_imm;
            r2_link <= r1_link;
            r2_pred <= r1_pred;
            r2_eq   <= r1_rs1 == r1_rs2;
            r2_lts  <= $signed(r1_rs1) < $signed(r1_rs2);
            r2_ltu  <= r1_rs1 < r1_rs2;
        end
    end

    always_comb begin
        n_taken        = 1'b0;
        n_ctrl         = 1'b0;
        n_next_pc      = r2_link;
        n_write_value  = 64'd0;
        n_write_enable = 1'b0;
        case (r2_kind)
            brju_pkg::K_ADDI, brju_pkg::K_AUIPC: begin
                n_write_value  = r2_sum;
                n_write_enable = r2_rd != 5'd0;
            end
            brju_pkg::K_BRANCH: begin
                n_ctrl = 1'b1;
                case (r2_f3)
                    brju_pkg::F3_BEQ:  n_taken = r2_eq;
                    brju_pkg::F3_BNE:  n_taken = !r2_eq;
                    brju_pkg::F3_BLT:  n_taken = r2_lts;
                    brju_pkg::F3_BGE:  n_taken = !r2_lts;
                    brju_pkg::F3_BLTU: n_taken = r2_ltu;
                    brju_pkg::F3_BGEU: n_taken = !r2_ltu;
                    default:           n_taken = 1'b0;
                endcase
                if (n_taken) begin
                    n_next_pc = r2_sum;
                end
            end
            brju_pkg::K_JALR: begin
                n_ctrl         = 1'b1;
                n_taken        = 1'b1;
                n_next_pc      = {r2_sum[63:1], 1'b0};
                n_write_value  = r2_link;
                n_write_enable = r2_rd != 5'd0;
            end
            brju_pkg::K_JAL: begin
                n_ctrl         = 1'b1;
                n_taken        = 1'b1;
                n_next_pc      = r2_sum;
                n_write_value  = r2_link;
                n_write_enable = r2_rd != 5'd0;
            end
            default: begin
                n_taken = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv3) begin
            r_next_pc      <= n_next_pc;
            r_mispredict   <= n_ctrl && (n_next_pc != r2_pred);
            r_is_control   <= n_ctrl;
            r_branch_taken <= n_taken;
            r_write_value  <= n_write_value;
            r_write_enable <= n_write_enable;
            r_dest_reg     <= r2_rd;
            r_unsupported  <= r2_kind == brju_pkg::K_UNSUP;
        end
    end

    assign o_valid        = r_v3;
    assign o_next_pc      = r_next_pc;
    assign o_mispredict   = r_mispredict;
    assign o_is_control   = r_is_control;
    assign o_branch_taken = r_branch_taken;
    assign o_write_value  = r_write_value;
    assign o_write_enable = r_write_enable;
    assign o_dest_reg     = r_dest_reg;
    assign o_unsupported  = r_unsupported;

endmodule

// ===== sv/brju_checker.sv =====
// Port-level checker for branch_jump_resolve_unit, attached by bind.
// Depends on branch_jump_resolve_unit_defines.svh.
`include "branch_jump_resolve_unit_defines.svh"

module brju_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_next_pc,
    input logic        o_mispredict,
    input logic        o_is_control,
    input logic        o_branch_taken,
    input logic [63:0] o_write_value,
    input logic        o_write_enable,
    input logic        o_unsupported
);

    `BRJU_ASSERT_NEXT(a_hold_stalled, o_valid && i_stall, o_valid && $stable(o_next_pc))
    `BRJU_ASSERT_NOW(a_mispredict_ctrl, o_valid && o_mispredict, o_is_control)
    `BRJU_ASSERT_NOW(a_taken_ctrl, o_valid && o_branch_taken, o_is_control)
    `BRJU_ASSERT_NOW(a_unsup_quiet, o_valid && o_unsupported, !o_is_control && !o_write_enable && (o_write_value == 64'd0))
    `BRJU_ASSERT_RESET(a_reset_empty, !o_valid)

endmodule

bind branch_jump_resolve_unit brju_checker u_brju_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_next_pc      (o_next_pc),
    .o_mispredict   (o_mispredict),
    .o_is_control   (o_is_control),
    .o_branch_taken (o_branch_taken),
    .o_write_value  (o_write_value),
    .o_write_enable (o_write_enable),
    .o_unsupported  (o_unsupported)
);
